@@ rtl/swwc_pkg.sv @@
// ----------------------------------------------------------------------------
// swwc_pkg: shared types, constants and the function of the schedule window check
// Holds the configuration layout, the range test used for the date, weekday
// and time-of-day windows, and the register index codes.
// ----------------------------------------------------------------------------
package swwc_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_YEAR   = 3'd0;
  localparam logic [2:0] REG_MONTH  = 3'd1;
  localparam logic [2:0] REG_MDAY   = 3'd2;
  localparam logic [2:0] REG_WDAY   = 3'd3;
  localparam logic [2:0] REG_HOUR   = 3'd4;
  localparam logic [2:0] REG_MINUTE = 3'd5;
  localparam logic [2:0] REG_CONT   = 3'd6;

  localparam logic [11:0] YEAR_UNSET   = 12'hFFF;
  localparam logic [3:0]  MONTH_UNSET  = 4'hF;
  localparam logic [5:0]  DAY_UNSET    = 6'h3F;
  localparam logic [2:0]  WDAY_UNSET   = 3'h7;
  localparam logic [4:0]  HOUR_UNSET   = 5'h1F;
  localparam logic [5:0]  MINUTE_UNSET = 6'h3F;

  localparam int YEAR_WEIGHT  = 372;
  localparam int MONTH_WEIGHT = 31;
  localparam int HOUR_MINUTES = 60;
  localparam int DATE_SPAN    = 1116000;
  localparam int DAY_MINUTES  = 1440;
  localparam int WEEK_SPAN    = 7;

  localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

  typedef logic signed [23:0] rt_val_t;
  typedef logic signed [33:0] verdict_t;

  localparam rt_val_t RT_BOTH     = rt_val_t'(-3);
  localparam rt_val_t RT_STOP     = rt_val_t'(-2);
  localparam rt_val_t RT_START    = rt_val_t'(-1);
  localparam rt_val_t RT_INSIDE   = rt_val_t'(0);
  localparam rt_val_t UNSET_BOUND = rt_val_t'(-1);

  typedef struct packed {
    logic [11:0] year_lo;
    logic [11:0] year_hi;
    logic [3:0]  month_lo;
    logic [3:0]  month_hi;
    logic [5:0]  day_lo;
    logic [5:0]  day_hi;
    logic [2:0]  wday_lo;
    logic [2:0]  wday_hi;
    logic [4:0]  hour_lo;
    logic [4:0]  hour_hi;
    logic [5:0]  minute_lo;
    logic [5:0]  minute_hi;
    logic        cont;
  } cfg_t;

  typedef struct packed {
    logic     active;
    rt_val_t  code;
    logic     hit;
    verdict_t value;
  } date_res_t;

  typedef struct packed {
    logic        in_window;
    logic [30:0] wait_minutes;
  } result_t;

  // Negative codes mark an exact hit on a bound; zero means inside;
  // a positive value is the distance to the start bound.
  function automatic rt_val_t range_test(input rt_val_t s, input rt_val_t e,
                                         input rt_val_t now, input rt_val_t span);
    rt_val_t r;
    if (s == now && e == now) begin
      r = RT_BOTH;
    end else if (s == now) begin
      r = RT_START;
    end else if (e == now) begin
      r = RT_STOP;
    end else if (s < 0 || e < 0) begin
      r = RT_INSIDE;
    end else if (s < e) begin
      if (s < now && e > now) begin
        r = RT_INSIDE;
      end else if (s < now && e < now) begin
        r = span - now + s;
      end else begin
        r = s - now;
      end
    end else if (s > e) begin
      if (s > now && e > now) begin
        r = RT_INSIDE;
      end else if (s > now && e < now) begin
        r = s - now;
      end else begin
        r = RT_INSIDE;
      end
    end else if (s < now) begin
      r = span - now + s;
    end else begin
      r = s - now;
    end
    return r;
  endfunction

endpackage

@@ rtl/swwc_ifs.sv @@
// ----------------------------------------------------------------------------
// swwc_ifs: channel interfaces of the schedule window check
// The time channel carries one calendar time per beat; the verdict channel
// carries the in-window flag and the wait in minutes.
// ----------------------------------------------------------------------------
interface swwc_time_if;
  logic        valid;
  logic        ready;
  logic [11:0] now_year;
  logic [3:0]  now_month;
  logic [4:0]  now_day;
  logic [2:0]  now_weekday;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;

  modport source (output valid, now_year, now_month, now_day, now_weekday, now_hour,
                  now_minute, input ready);
  modport sink (input valid, now_year, now_month, now_day, now_weekday, now_hour,
                now_minute, output ready);
endinterface

interface swwc_verdict_if;
  logic        valid;
  logic        ready;
  logic        in_window;
  logic [30:0] wait_minutes;

  modport source (output valid, in_window, wait_minutes, input ready);
  modport sink (input valid, in_window, wait_minutes, output ready);
endinterface

@@ rtl/swwc_cfg.sv @@
// ----------------------------------------------------------------------------
// swwc_cfg: configuration register file
// APB-style slave holding the schedule window bounds and the continued-time
// flag. Writes complete in the access phase; reads return the stored value.
// ----------------------------------------------------------------------------
module swwc_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [swwc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output swwc_pkg::cfg_t            cfg
);

  logic [23:0] year_window;
  logic [7:0]  month_window;
  logic [11:0] mday_window;
  logic [5:0]  wday_window;
  logic [9:0]  hour_window;
  logic [11:0] minute_window;
  logic        continued_time;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_window    <= '1;
      month_window   <= '1;
      mday_window    <= '1;
      wday_window    <= '1;
      hour_window    <= '1;
      minute_window  <= '1;
      continued_time <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        swwc_pkg::REG_YEAR:   year_window    <= pwdata[23:0];
        swwc_pkg::REG_MONTH:  month_window   <= pwdata[7:0];
        swwc_pkg::REG_MDAY:   mday_window    <= pwdata[11:0];
        swwc_pkg::REG_WDAY:   wday_window    <= pwdata[5:0];
        swwc_pkg::REG_HOUR:   hour_window    <= pwdata[9:0];
        swwc_pkg::REG_MINUTE: minute_window  <= pwdata[11:0];
        swwc_pkg::REG_CONT:   continued_time <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swwc_pkg::REG_YEAR:   prdata = {8'd0, year_window};
      swwc_pkg::REG_MONTH:  prdata = {24'd0, month_window};
      swwc_pkg::REG_MDAY:   prdata = {20'd0, mday_window};
      swwc_pkg::REG_WDAY:   prdata = {26'd0, wday_window};
      swwc_pkg::REG_HOUR:   prdata = {22'd0, hour_window};
      swwc_pkg::REG_MINUTE: prdata = {20'd0, minute_window};
      swwc_pkg::REG_CONT:   prdata = {31'd0, continued_time};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg.year_lo   = year_window[11:0];
  assign cfg.year_hi   = year_window[23:12];
  assign cfg.month_lo  = month_window[3:0];
  assign cfg.month_hi  = month_window[7:4];
  assign cfg.day_lo    = mday_window[5:0];
  assign cfg.day_hi    = mday_window[11:6];
  assign cfg.wday_lo   = wday_window[2:0];
  assign cfg.wday_hi   = wday_window[5:3];
  assign cfg.hour_lo   = hour_window[4:0];
  assign cfg.hour_hi   = hour_window[9:5];
  assign cfg.minute_lo = minute_window[5:0];
  assign cfg.minute_hi = minute_window[11:6];
  assign cfg.cont      = continued_time;

endmodule

@@ rtl/swwc_date.sv @@
// ----------------------------------------------------------------------------
// swwc_date: date window test
// Folds the set date bounds and the current date into one mixed-radix value,
// runs the range test and decides whether the date alone settles the verdict.
// ----------------------------------------------------------------------------
module swwc_date (
  input  swwc_pkg::cfg_t      cfg,
  input  logic [11:0]         now_year,
  input  logic [3:0]          now_month,
  input  logic [4:0]          now_day,
  input  logic [4:0]          now_hour,
  input  logic [5:0]          now_minute,
  output swwc_pkg::date_res_t date
);

  logic               y_set;
  logic               m_set;
  logic               d_set;
  logic [11:0]        ya;
  logic [11:0]        yb;
  logic [11:0]        yn;
  logic [3:0]         ma;
  logic [3:0]         mb;
  logic [4:0]         mn;
  logic [5:0]         da;
  logic [5:0]         db;
  logic [20:0]        fa;
  logic [20:0]        fb;
  logic [20:0]        fn;
  swwc_pkg::rt_val_t  code;
  logic               hs0;
  logic               hs1;
  logic               ns0;
  logic               ns1;
  logic [10:0]        t0;
  logic [10:0]        c0;
  logic [10:0]        t1;
  logic [10:0]        c1;
  logic [33:0]        prod;

  // A time of day built from whichever of hour and minute is set.
  function automatic logic [10:0] clock_point(input logic hset, input logic [4:0] h,
                                              input logic nset, input logic [5:0] n);
    logic [10:0] hh;
    hh = hset ? {6'd0, h} : 11'd0;
    if (nset) begin
      return hh * 11'(swwc_pkg::HOUR_MINUTES) + {5'd0, n};
    end
    return hh;
  endfunction

  assign y_set = cfg.year_lo != swwc_pkg::YEAR_UNSET && cfg.year_hi != swwc_pkg::YEAR_UNSET
                 && cfg.year_lo <= cfg.year_hi;
  assign m_set = cfg.month_lo != swwc_pkg::MONTH_UNSET
                 && cfg.month_hi != swwc_pkg::MONTH_UNSET;
  assign d_set = cfg.day_lo != swwc_pkg::DAY_UNSET && cfg.day_hi != swwc_pkg::DAY_UNSET;

  assign ya = y_set ? cfg.year_lo : 12'd0;
  assign yb = y_set ? cfg.year_hi : 12'd0;
  assign yn = y_set ? now_year : 12'd0;
  assign ma = m_set ? cfg.month_lo : 4'd0;
  assign mb = m_set ? cfg.month_hi : 4'd0;
  assign mn = m_set ? {1'b0, now_month} + 5'd1 : (y_set ? {1'b0, now_month} : 5'd0);
  assign da = d_set ? cfg.day_lo : 6'd0;
  assign db = d_set ? cfg.day_hi : 6'd0;

  assign fa = {9'd0, ya} * 21'(swwc_pkg::YEAR_WEIGHT)
            + {17'd0, ma} * 21'(swwc_pkg::MONTH_WEIGHT) + {15'd0, da};
  assign fb = {9'd0, yb} * 21'(swwc_pkg::YEAR_WEIGHT)
            + {17'd0, mb} * 21'(swwc_pkg::MONTH_WEIGHT) + {15'd0, db};
  assign fn = {9'd0, yn} * 21'(swwc_pkg::YEAR_WEIGHT)
            + {16'd0, mn} * 21'(swwc_pkg::MONTH_WEIGHT) + {16'd0, now_day};

  assign code = swwc_pkg::range_test(swwc_pkg::rt_val_t'({3'd0, fa}),
                                     swwc_pkg::rt_val_t'({3'd0, fb}),
                                     swwc_pkg::rt_val_t'({3'd0, fn}),
                                     swwc_pkg::rt_val_t'(swwc_pkg::DATE_SPAN));

  assign hs0 = cfg.hour_lo != swwc_pkg::HOUR_UNSET;
  assign hs1 = cfg.hour_hi != swwc_pkg::HOUR_UNSET;
  assign ns0 = cfg.minute_lo != swwc_pkg::MINUTE_UNSET;
  assign ns1 = cfg.minute_hi != swwc_pkg::MINUTE_UNSET;

  assign t0 = clock_point(hs0, cfg.hour_lo, ns0, cfg.minute_lo);
  assign c0 = clock_point(hs0, now_hour, ns0, now_minute);
  assign t1 = clock_point(hs1, cfg.hour_hi, ns1, cfg.minute_hi);
  assign c1 = clock_point(hs1, now_hour, ns1, now_minute);

  assign prod = {11'd0, code[22:0]} * 34'(swwc_pkg::DAY_MINUTES);

  always_comb begin
    date.active = y_set || m_set || d_set;
    date.code   = code;
    date.hit    = 1'b0;
    date.value  = '0;
    if (date.active) begin
      if (code > 0) begin
        date.hit   = 1'b1;
        date.value = swwc_pkg::verdict_t'(prod);
      end else if (cfg.cont) begin
        if (code == swwc_pkg::RT_INSIDE) begin
          date.hit = 1'b1;
        end else if (code == swwc_pkg::RT_START && (hs0 || ns0)) begin
          date.hit = c0 >= t0;
        end else if (code == swwc_pkg::RT_STOP && (hs1 || ns1)) begin
          date.hit = c1 < t1;
        end
      end
    end
  end

endmodule

@@ rtl/swwc_verdict.sv @@
// ----------------------------------------------------------------------------
// swwc_verdict: weekday and time-of-day test and final verdict
// Combines the date outcome with the weekday window and the hour:minute
// window, then forms the in-window flag and the saturated wait.
// ----------------------------------------------------------------------------
module swwc_verdict (
  input  swwc_pkg::cfg_t      cfg,
  input  swwc_pkg::date_res_t date,
  input  logic [2:0]          now_weekday,
  input  logic [4:0]          now_hour,
  input  logic [5:0]          now_minute,
  output swwc_pkg::result_t   result
);

  swwc_pkg::rt_val_t  ws;
  swwc_pkg::rt_val_t  we;
  swwc_pkg::rt_val_t  day_r;
  swwc_pkg::rt_val_t  min_r;
  swwc_pkg::rt_val_t  min_r2;
  swwc_pkg::rt_val_t  ta_s;
  swwc_pkg::rt_val_t  tb_s;
  logic               h_set;
  logic               n_set;
  logic [10:0]        ta;
  logic [10:0]        tb;
  logic [10:0]        tn;
  logic [10:0]        tn1;
  logic               at_start;
  logic               at_stop;
  logic [33:0]        day_prod;
  swwc_pkg::verdict_t r;

  assign ws = (cfg.wday_lo == swwc_pkg::WDAY_UNSET) ? swwc_pkg::UNSET_BOUND
                                                    : swwc_pkg::rt_val_t'({21'd0, cfg.wday_lo});
  assign we = (cfg.wday_hi == swwc_pkg::WDAY_UNSET) ? swwc_pkg::UNSET_BOUND
                                                    : swwc_pkg::rt_val_t'({21'd0, cfg.wday_hi});
  assign day_r = swwc_pkg::range_test(ws, we, swwc_pkg::rt_val_t'({21'd0, now_weekday}),
                                      swwc_pkg::rt_val_t'(swwc_pkg::WEEK_SPAN));
  assign day_prod = {11'd0, day_r[22:0]} * 34'(swwc_pkg::DAY_MINUTES);

  assign h_set = cfg.hour_lo != swwc_pkg::HOUR_UNSET && cfg.hour_hi != swwc_pkg::HOUR_UNSET;
  assign n_set = cfg.minute_lo != swwc_pkg::MINUTE_UNSET
                 && cfg.minute_hi != swwc_pkg::MINUTE_UNSET;

  assign ta  = (h_set ? {6'd0, cfg.hour_lo} * 11'(swwc_pkg::HOUR_MINUTES) : 11'd0)
             + (n_set ? {5'd0, cfg.minute_lo} : 11'd0);
  assign tb  = (h_set ? {6'd0, cfg.hour_hi} * 11'(swwc_pkg::HOUR_MINUTES) : 11'd0)
             + (n_set ? {5'd0, cfg.minute_hi} : 11'd0);
  assign tn  = (h_set ? {6'd0, now_hour} * 11'(swwc_pkg::HOUR_MINUTES) : 11'd0)
             + {5'd0, now_minute};
  assign tn1 = tn + 11'd1;

  assign ta_s = swwc_pkg::rt_val_t'({13'd0, ta});
  assign tb_s = swwc_pkg::rt_val_t'({13'd0, tb});

  assign min_r  = swwc_pkg::range_test(ta_s, tb_s, swwc_pkg::rt_val_t'({13'd0, tn}),
                                       swwc_pkg::rt_val_t'(swwc_pkg::DAY_MINUTES));
  assign min_r2 = swwc_pkg::range_test(ta_s, tb_s, swwc_pkg::rt_val_t'({13'd0, tn1}),
                                       swwc_pkg::rt_val_t'(swwc_pkg::DAY_MINUTES));

  assign at_start = day_r == swwc_pkg::RT_START
                    || (date.active && date.code == swwc_pkg::RT_START);
  assign at_stop  = day_r == swwc_pkg::RT_STOP
                    || (date.active && date.code == swwc_pkg::RT_STOP);

  always_comb begin
    r = '0;
    if (date.hit) begin
      r = date.value;
    end else if (day_r > 0) begin
      r = swwc_pkg::verdict_t'(day_prod);
    end else if (cfg.cont && day_r == swwc_pkg::RT_INSIDE
                 && cfg.wday_lo != swwc_pkg::WDAY_UNSET
                 && cfg.wday_hi != swwc_pkg::WDAY_UNSET) begin
      r = '0;
    end else if (!(h_set || n_set) || ta == tb) begin
      r = '0;
    end else if (cfg.cont && ta < tb
                 && ((tn < ta && at_stop) || (tn > tb && at_start))) begin
      r = '0;
    end else if (cfg.cont && ta > tb && tn < ta && at_start) begin
      r = swwc_pkg::verdict_t'(min_r + (ta_s - tb_s));
    end else if (cfg.cont && ta > tb && tn > tb && at_stop) begin
      r = swwc_pkg::verdict_t'(swwc_pkg::DAY_MINUTES) - swwc_pkg::verdict_t'({23'd0, tb});
    end else if (min_r > 0) begin
      r = swwc_pkg::verdict_t'(min_r);
    end else if (min_r == swwc_pkg::RT_STOP && min_r2 > 0) begin
      r = swwc_pkg::verdict_t'(min_r2) + swwc_pkg::verdict_t'(1);
    end
  end

  always_comb begin
    result.in_window = r == '0;
    if (r < 0) begin
      result.wait_minutes = '0;
    end else if (r > swwc_pkg::verdict_t'({3'd0, swwc_pkg::WAIT_MAX})) begin
      result.wait_minutes = swwc_pkg::WAIT_MAX;
    end else begin
      result.wait_minutes = r[30:0];
    end
  end

endmodule

@@ rtl/schedule_window_wait_check_unit.sv @@
// ----------------------------------------------------------------------------
// schedule_window_wait_check_unit: schedule window check, top level
// Each beat on time_in carries one calendar time (year, zero-based month,
// day, weekday, hour, minute). Each produces exactly one beat on verdict_out:
// in_window is 1 when the time lies inside the configured schedule window,
// and wait_minutes gives the minutes until the window opens, 0 when inside.
// The window bounds sit in APB registers at byte offsets 4*i; program them
// only while no beat is in flight.
// The verdict is registered: the time is held in an input register, and the
// date, weekday and time-of-day tests are evaluated in one pass into the
// result register. A new beat is accepted in every cycle while verdict_out
// does not stall, so throughput is then one beat per clock.
// When verdict_out stalls, the result register holds its beat and the input
// register still takes one more beat; time_in.ready drops only when both are
// full. Synchronous reset empties both stages and restores every bound to
// unset with continued time off.
// ----------------------------------------------------------------------------
module schedule_window_wait_check_unit (
  input  logic                        clk,
  input  logic                        rst,
  swwc_time_if.sink                   time_in,
  swwc_verdict_if.source              verdict_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swwc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  swwc_pkg::cfg_t      cfg;
  swwc_pkg::date_res_t date;
  swwc_pkg::result_t   result;

  logic        s1_valid;
  logic [11:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [2:0]  s1_weekday;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_minute;
  logic        res_valid;
  logic        res_in_window;
  logic [30:0] res_wait;
  logic        res_free;
  logic        s2_load;

  swwc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swwc_date u_date (
    .cfg        (cfg),
    .now_year   (s1_year),
    .now_month  (s1_month),
    .now_day    (s1_day),
    .now_hour   (s1_hour),
    .now_minute (s1_minute),
    .date       (date)
  );

  swwc_verdict u_verdict (
    .cfg         (cfg),
    .date        (date),
    .now_weekday (s1_weekday),
    .now_hour    (s1_hour),
    .now_minute  (s1_minute),
    .result      (result)
  );

  assign res_free      = !res_valid || verdict_out.ready;
  assign s2_load       = s1_valid && res_free;
  assign time_in.ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (time_in.ready) begin
        s1_valid <= time_in.valid;
      end
      if (res_free) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (time_in.valid && time_in.ready) begin
      s1_year    <= time_in.now_year;
      s1_month   <= time_in.now_month;
      s1_day     <= time_in.now_day;
      s1_weekday <= time_in.now_weekday;
      s1_hour    <= time_in.now_hour;
      s1_minute  <= time_in.now_minute;
    end
    if (s2_load) begin
      res_in_window <= result.in_window;
      res_wait      <= result.wait_minutes;
    end
  end

  assign verdict_out.valid        = res_valid;
  assign verdict_out.in_window    = res_in_window;
  assign verdict_out.wait_minutes = res_wait;

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res_valid |=> res_valid)
    else $error("Input stage beat did not move into an empty result stage.");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !verdict_out.ready && s1_valid |-> !time_in.ready)
    else $error("Input accepted while both stages were full and stalled.");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    time_in.valid && time_in.ready |=> s1_valid)
    else $error("Accepted beat was not captured in the input stage.");

  a_window_zero_wait: assert property (@(posedge clk) disable iff (rst)
    s2_load && result.in_window |=> res_wait == 31'd0)
    else $error("Verdict inside the window carries a nonzero wait.");

endmodule
